// ===== design/kps_pkg.sv =====
package kps_pkg;

	localparam int ACTION_W = 3;
	localparam int CHAR_W = 8;
	localparam int STATUS_W = 2;
	localparam int DIGIT_W = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ALPHA = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_KEY = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ENCRYPT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DECRYPT = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 1'd1;

	localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 4'd10;
	localparam logic [CFG_DATA_W-1:0] COLUMNS_RESET = 4'd10;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_START    = 8'b0000_0010,
		S_SCAN     = 8'b0000_0100,
		S_SHIFT_RD = 8'b0000_1000,
		S_SHIFT_WR = 8'b0001_0000,
		S_DEC_RD   = 8'b0010_0000,
		S_EMIT0    = 8'b0100_0000,
		S_EMIT1    = 8'b1000_0000
	} seq_state_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] v);
		logic [CHAR_W-1:0] c;
		if (v < 4'd10) begin
			c = CH_ZERO + CHAR_W'(v);
		end else begin
			c = CH_UPPER_A + CHAR_W'(v - 4'd10);
		end
		return c;
	endfunction

	// Bit 4 flags a valid hex digit, bits 3:0 carry its value.
	function automatic logic [DIGIT_W:0] hex_value(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W:0] r;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, DIGIT_W'(c - CH_ZERO)};
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			r = {1'b1, DIGIT_W'(c - CH_UPPER_A + 8'd10)};
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

// ===== design/kps_if.sv =====
interface kps_item_if import kps_pkg::*;;
	logic valid;
	logic ready;
	logic [ACTION_W-1:0] action;
	logic [CHAR_W-1:0] data_char;

	modport source (output valid, output action, output data_char, input ready);
	modport sink (input valid, input action, input data_char, output ready);
endinterface

interface kps_result_if import kps_pkg::*;;
	logic valid;
	logic ready;
	logic [CHAR_W-1:0] out_char;
	logic has_char;
	logic [STATUS_W-1:0] status;
	logic last;

	modport source (output valid, output out_char, output has_char, output status,
		output last, input ready);
	modport sink (input valid, input out_char, input has_char, input status,
		input last, output ready);
endinterface

// ===== design/kps_mem.sv =====
module kps_mem import kps_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CHAR_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem_q [DEPTH];
	logic [CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/keyed_polybius_square_cipher.sv =====
// Keyed Polybius square: alphabet, key, encrypt and decrypt items share one symbol
// memory with a single registered read port and one comparator, so the block takes
// one item at a time. Clear, alphabet and decrypt space or newline items go from
// the start state straight to the result; a decrypt character that is not a digit,
// a first decrypt digit and an unknown action give no result beat; a second decrypt
// digit reads the memory, unless the entry is past the alphabet count. Encrypt and
// key items scan the stored symbols one per cycle and stop at the first match or at
// the alphabet count; a key item that moves symbols reads and rewrites each entry
// from the key position to the match, both included. An encrypt item that gives two
// beats emits the second after the first, and a result beat waits while the output
// register is full and not taken. Entries beyond the alphabet count are never
// matched, and decrypting one gives a NUL character, so clear needs no pass over
// the memory.
module keyed_polybius_square_cipher import kps_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	kps_item_if.sink               item,
	kps_result_if.source           result,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	seq_state_t state_q;

	logic [CFG_DATA_W-1:0] rows_q;
	logic [CFG_DATA_W-1:0] cols_q;
	logic [CW-1:0] alpha_count_q;
	logic [CW-1:0] key_count_q;
	logic have_row_q;
	logic [DIGIT_W-1:0] row_digit_q;

	logic [ACTION_W-1:0] act_q;
	logic [CHAR_W-1:0] char_q;

	logic [CW-1:0] addr_q;
	logic [DIGIT_W-1:0] row_q;
	logic [DIGIT_W-1:0] col_q;
	logic pend_s1;
	logic [AW-1:0] pos_s1;
	logic [DIGIT_W-1:0] row_s1;
	logic [DIGIT_W-1:0] col_s1;

	logic [AW-1:0] shift_idx_q;
	logic [AW-1:0] shift_end_q;
	logic [CHAR_W-1:0] carry_q;

	logic [CHAR_W-1:0] res_char0_q;
	logic res_has0_q;
	logic [STATUS_W-1:0] res_st0_q;
	logic res_two_q;
	logic [CHAR_W-1:0] res_char1_q;

	logic out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic out_has_q;
	logic [STATUS_W-1:0] out_st_q;
	logic out_last_q;

	logic [CFG_DATA_W-1:0] rows_eff;
	logic [CFG_DATA_W-1:0] cols_eff;
	logic [7:0] capacity;
	logic table_full;
	logic [DIGIT_W:0] hv;
	logic [7:0] dec_idx;
	logic dec_in_range;
	logic is_blank;
	logic hit;
	logic scan_end;
	logic can_load;
	logic out_load;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CHAR_W-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [CHAR_W-1:0] mem_rdata;

	kps_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rows_eff = (rows_q == '0) ? CFG_DATA_W'(1) : rows_q;
	assign cols_eff = (cols_q == '0) ? CFG_DATA_W'(1) : cols_q;
	assign capacity = 8'(rows_eff) * 8'(cols_eff);
	assign table_full = (9'(alpha_count_q) >= 9'(capacity))
		|| (alpha_count_q == CW'(TABLE_DEPTH));

	assign hv = hex_value(char_q);
	assign dec_idx = 8'(row_digit_q) * 8'(cols_eff) + 8'(hv[DIGIT_W-1:0]);
	assign dec_in_range = 9'(dec_idx) < 9'(alpha_count_q);

	assign is_blank = (char_q == CH_SPACE) || (char_q == CH_TAB) || (char_q == CH_NEWLINE);
	assign hit = pend_s1 && (mem_rdata == char_q);
	assign scan_end = hit || (!pend_s1 && (addr_q >= alpha_count_q));
	assign can_load = !out_valid_q || result.ready;
	assign out_load = can_load && ((state_q == S_EMIT0) || (state_q == S_EMIT1));

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = alpha_count_q[AW-1:0];
		mem_wdata = char_q;
		mem_raddr = addr_q[AW-1:0];
		case (state_q)
			S_START: begin
				mem_we = (act_q == ACT_ALPHA) && !table_full;
				mem_raddr = dec_idx[AW-1:0];
			end
			S_SHIFT_RD: begin
				mem_raddr = shift_idx_q;
			end
			S_SHIFT_WR: begin
				mem_we = 1'b1;
				mem_waddr = shift_idx_q;
				mem_wdata = carry_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLUMNS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROWS: rows_q <= cfg_data;
				REG_COLUMNS: cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			alpha_count_q <= '0;
			key_count_q <= '0;
			have_row_q <= 1'b0;
			row_digit_q <= '0;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						act_q <= item.action;
						char_q <= item.data_char;
						state_q <= S_START;
					end
				end
				S_START: begin
					res_char0_q <= CH_NUL;
					res_has0_q <= 1'b0;
					res_st0_q <= ST_OK;
					res_two_q <= 1'b0;
					addr_q <= '0;
					row_q <= '0;
					col_q <= '0;
					pend_s1 <= 1'b0;
					case (act_q)
						ACT_CLEAR: begin
							alpha_count_q <= '0;
							key_count_q <= '0;
							have_row_q <= 1'b0;
							row_digit_q <= '0;
							state_q <= S_EMIT0;
						end
						ACT_ALPHA: begin
							if (table_full) begin
								res_st0_q <= ST_FULL;
							end else begin
								alpha_count_q <= alpha_count_q + CW'(1);
							end
							state_q <= S_EMIT0;
						end
						ACT_KEY, ACT_ENCRYPT: begin
							state_q <= S_SCAN;
						end
						ACT_DECRYPT: begin
							if (char_q == CH_SPACE || char_q == CH_NEWLINE) begin
								res_char0_q <= char_q;
								res_has0_q <= 1'b1;
								state_q <= S_EMIT0;
							end else if (!hv[DIGIT_W]) begin
								state_q <= S_IDLE;
							end else if (!have_row_q) begin
								row_digit_q <= hv[DIGIT_W-1:0];
								have_row_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								have_row_q <= 1'b0;
								res_has0_q <= 1'b1;
								state_q <= dec_in_range ? S_DEC_RD : S_EMIT0;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SCAN: begin
					if (scan_end) begin
						pend_s1 <= 1'b0;
						if (act_q == ACT_KEY) begin
							if (!hit) begin
								res_st0_q <= ST_NOT_FOUND;
								state_q <= S_EMIT0;
							end else if (CW'(pos_s1) < key_count_q) begin
								res_st0_q <= ST_DUPLICATE;
								state_q <= S_EMIT0;
							end else begin
								shift_idx_q <= key_count_q[AW-1:0];
								shift_end_q <= pos_s1;
								carry_q <= char_q;
								state_q <= S_SHIFT_RD;
							end
						end else begin
							if (hit && (pos_s1 == '0 || !is_blank)) begin
								res_char0_q <= hex_char(row_s1);
								res_has0_q <= 1'b1;
								res_char1_q <= hex_char(col_s1);
								res_two_q <= 1'b1;
							end else if (is_blank) begin
								res_char0_q <= (char_q == CH_NEWLINE) ? CH_NEWLINE : CH_SPACE;
								res_has0_q <= 1'b1;
							end else begin
								res_st0_q <= ST_NOT_FOUND;
							end
							state_q <= S_EMIT0;
						end
					end else if (addr_q < alpha_count_q) begin
						pend_s1 <= 1'b1;
						pos_s1 <= addr_q[AW-1:0];
						row_s1 <= row_q;
						col_s1 <= col_q;
						addr_q <= addr_q + CW'(1);
						if (col_q == cols_eff - CFG_DATA_W'(1)) begin
							col_q <= '0;
							row_q <= row_q + DIGIT_W'(1);
						end else begin
							col_q <= col_q + DIGIT_W'(1);
						end
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					carry_q <= mem_rdata;
					if (shift_idx_q == shift_end_q) begin
						key_count_q <= key_count_q + CW'(1);
						state_q <= S_EMIT0;
					end else begin
						shift_idx_q <= shift_idx_q + AW'(1);
						state_q <= S_SHIFT_RD;
					end
				end
				S_DEC_RD: begin
					res_char0_q <= mem_rdata;
					state_q <= S_EMIT0;
				end
				S_EMIT0: begin
					if (can_load) begin
						out_char_q <= res_char0_q;
						out_has_q <= res_has0_q;
						out_st_q <= res_st0_q;
						out_last_q <= !res_two_q;
						state_q <= res_two_q ? S_EMIT1 : S_IDLE;
					end
				end
				S_EMIT1: begin
					if (can_load) begin
						out_char_q <= res_char1_q;
						out_has_q <= 1'b1;
						out_st_q <= ST_OK;
						out_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item.ready = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.out_char = out_char_q;
	assign result.has_char = out_has_q;
	assign result.status = out_st_q;
	assign result.last = out_last_q;

endmodule

// ===== design/kps_checker.sv =====
module kps_checker import kps_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input logic [CHAR_W-1:0]   result_char,
	input logic                result_has_char,
	input logic [STATUS_W-1:0] result_status,
	input logic                result_last
);

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_char)
		&& $stable(result_last))
		else $error("stalled result beat changed");

	// Only the row digit of an encrypted symbol is followed by another beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_last |-> result_has_char && result_status == ST_OK
		&& ((result_char >= CH_ZERO && result_char <= CH_NINE)
		|| (result_char >= CH_UPPER_A && result_char <= CH_UPPER_F)))
		else $error("non-final beat is not a hex digit");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_status != ST_OK |-> !result_has_char && result_last)
		else $error("error beat carries a character");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_has_char |-> result_char == CH_NUL)
		else $error("empty beat has a nonzero character");

endmodule

bind keyed_polybius_square_cipher kps_checker u_kps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_char     (result.out_char),
	.result_has_char (result.has_char),
	.result_status   (result.status),
	.result_last     (result.last)
);
